### hw/rtl/cfrm_pkg.sv
// ----------------------------------------------------------------------------
// cfrm_pkg
// Shared types and constants for the CAN frame rule matcher: item structs,
// command format between front and engine, rule table sizing, reset rules.
// ----------------------------------------------------------------------------
package cfrm_pkg;

	// rule table sizing
	localparam int NUM_RULES      = 16;
	localparam int MAX_DATA_BYTES = 8;
	localparam int RULE_IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int MAX_OUT        = 16;
	localparam int HIT_CNT_W      = $clog2(MAX_OUT + 1);
	localparam int DATA_W         = 64;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	// id constants
	localparam logic [31:0] ID_FULL_MASK  = 32'h1FFF_FFFF;
	localparam logic [31:0] ERR_RULE_ID   = 32'h2000_0000;
	localparam logic [31:0] OBD_RULE_ID   = 32'h0000_07DF;
	localparam logic [31:0] SFF_RULE_MASK = 32'h0000_07FF;

	// item function codes
	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_CHECK = 1'b1
	} func_t;

	// engine sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} eng_state_t;

	// input item
	typedef struct packed {
		logic        func;
		logic [3:0]  index;
		logic [31:0] can_id;
		logic [31:0] mask;
		logic [63:0] data;
		logic [3:0]  length;
		logic        rule_valid;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [3:0] rule_index;
		logic       hit;
		logic [4:0] hit_count;
		logic       last;
	} rsp_item_t;

	// classified command handed from front to engine
	typedef struct packed {
		logic        is_frame;
		logic        slot_ok;
		logic [3:0]  index;
		logic [31:0] can_id;
		logic [31:0] mask;
		logic [63:0] data;
		logic [3:0]  len;
		logic        rule_valid;
	} cmd_t;

	// queue head handshake toward the engine
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

### hw/rtl/cfrm_front.sv
// ----------------------------------------------------------------------------
// cfrm_front
// Accepts items, classifies them as rule load or frame check, saturates the
// length and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module cfrm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  cfrm_pkg::req_item_t req,
	output cfrm_pkg::q_head_t   head,
	input  logic                pop
);
	import cfrm_pkg::*;

	cmd_t              cmd_in;
	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	// classify and saturate
	always_comb begin
		cmd_in            = '0;
		cmd_in.is_frame   = (req.func == FUNC_CHECK);
		cmd_in.slot_ok    = (32'(req.index) < NUM_RULES);
		cmd_in.index      = req.index;
		cmd_in.can_id     = req.can_id;
		cmd_in.mask       = req.mask;
		cmd_in.data       = req.data;
		cmd_in.len        = (32'(req.length) > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES)
		                                                       : req.length;
		cmd_in.rule_valid = req.rule_valid;
	end

	assign req_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall;
	assign do_pop    = pop && (count_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= QUEUE_DEPTH)
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("engine pops an empty queue");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(QUEUE_DEPTH)) && !pop |=> req_stall)
		else $error("full queue not stalling");

endmodule

### hw/rtl/cfrm_engine.sv
// ----------------------------------------------------------------------------
// cfrm_engine
// Holds the rule table, applies loads, walks a frame's rules one per cycle
// unless a second hit waits on a busy output register; one result per hit.
// ----------------------------------------------------------------------------
module cfrm_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  cfrm_pkg::q_head_t   head,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cfrm_pkg::rsp_item_t rsp
);
	import cfrm_pkg::*;

	// rule table
	logic [31:0]       rid_q   [NUM_RULES];
	logic [31:0]       rmask_q [NUM_RULES];
	logic [DATA_W-1:0] rpat_q  [NUM_RULES];
	logic [3:0]        rlen_q  [NUM_RULES];
	logic              rval_q  [NUM_RULES];

	eng_state_t           state_q;
	eng_state_t           state_d;
	logic [RULE_IDX_W-1:0] scan_q;
	logic [HIT_CNT_W-1:0]  hits_q;
	logic [RULE_IDX_W-1:0] pend_idx_q;
	logic                  out_v_q;
	rsp_item_t             out_q;

	logic                  out_free;
	logic                  rule_hit;
	logic                  scan_end;
	logic                  table_we;
	logic [RULE_IDX_W-1:0] wr_addr;
	logic                  start;
	logic                  advance;
	logic                  take_hit;
	logic                  push;
	rsp_item_t             push_item;

	// payload search: pattern anywhere inside the frame bytes
	function automatic logic pat_found(logic [DATA_W-1:0] pl, logic [3:0] flen,
	                                   logic [DATA_W-1:0] pat, logic [3:0] plen);
		logic              found;
		logic              same;
		logic [DATA_W-1:0] win;
		found = (plen == 4'd0);
		for (int off = 0; off < MAX_DATA_BYTES; off++) begin
			win  = pl >> (8 * off);
			same = ((32'(plen) + off) <= 32'(flen));
			for (int k = 0; k < MAX_DATA_BYTES; k++) begin
				if ((k < 32'(plen)) && (win[8*k +: 8] != pat[8*k +: 8])) begin
					same = 1'b0;
				end
			end
			found = found | same;
		end
		return found;
	endfunction

	// id test for the rule under scan
	function automatic logic id_passes(logic [31:0] fid, logic [31:0] rid,
	                                   logic [31:0] rmask);
		logic [31:0] m;
		m = (rmask != '0) ? rmask : ID_FULL_MASK;
		return ((rid == '0) && (rmask == '0)) || ((fid & m) == (rid & m));
	endfunction

	assign out_free = !out_v_q || !rsp_stall;
	assign wr_addr  = RULE_IDX_W'(head.cmd.index);
	assign scan_end = (scan_q == RULE_IDX_W'(NUM_RULES - 1));
	assign rule_hit = rval_q[scan_q]
	               && id_passes(head.cmd.can_id, rid_q[scan_q], rmask_q[scan_q])
	               && pat_found(head.cmd.data, head.cmd.len, rpat_q[scan_q], rlen_q[scan_q]);

	// control outputs
	always_comb begin
		table_we  = 1'b0;
		start     = 1'b0;
		advance   = 1'b0;
		take_hit  = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		push_item = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (head.cmd.is_frame) begin
						start = 1'b1;
					end else begin
						table_we = head.cmd.slot_ok;
						pop      = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// a second hit must flush the pending one first
				if (!(rule_hit && (hits_q != '0) && !out_free)) begin
					advance  = 1'b1;
					take_hit = rule_hit;
					if (rule_hit && (hits_q != '0)) begin
						push                 = 1'b1;
						push_item.rule_index = 4'(pend_idx_q);
						push_item.hit        = 1'b1;
						push_item.hit_count  = 5'(hits_q);
						push_item.last       = 1'b0;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push = 1'b1;
					pop  = 1'b1;
					if (hits_q != '0) begin
						push_item.rule_index = 4'(pend_idx_q);
						push_item.hit        = 1'b1;
						push_item.hit_count  = 5'(hits_q);
					end
					push_item.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (advance && (scan_end ||
				    (take_hit && (32'(hits_q) + 1 == MAX_OUT)))) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (pop) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			hits_q     <= '0;
			pend_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				scan_q <= '0;
				hits_q <= '0;
			end else if (advance) begin
				if (!scan_end) begin
					scan_q <= scan_q + 1'b1;
				end
				if (take_hit) begin
					hits_q     <= hits_q + 1'b1;
					pend_idx_q <= scan_q;
				end
			end
		end
	end

	// rule table, reset to the error-frame and 0x7df rules
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RULES; i++) begin
				rid_q[i]   <= '0;
				rmask_q[i] <= '0;
				rpat_q[i]  <= '0;
				rlen_q[i]  <= '0;
				rval_q[i]  <= 1'b0;
			end
			rid_q[0]   <= ERR_RULE_ID;
			rmask_q[0] <= ERR_RULE_ID;
			rval_q[0]  <= 1'b1;
			rid_q[1]   <= OBD_RULE_ID;
			rmask_q[1] <= SFF_RULE_MASK;
			rval_q[1]  <= 1'b1;
		end else if (table_we) begin
			if (head.cmd.rule_valid) begin
				rid_q[wr_addr]   <= head.cmd.can_id;
				rmask_q[wr_addr] <= head.cmd.mask;
				rpat_q[wr_addr]  <= head.cmd.data;
				rlen_q[wr_addr]  <= head.cmd.len;
				rval_q[wr_addr]  <= 1'b1;
			end else begin
				rid_q[wr_addr]   <= '0;
				rmask_q[wr_addr] <= '0;
				rpat_q[wr_addr]  <= '0;
				rlen_q[wr_addr]  <= '0;
				rval_q[wr_addr]  <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_item;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over a waiting result");

	a_scan_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FINISH) |-> head.valid && head.cmd.is_frame)
		else $error("frame left the queue head during scan");

	a_pop_point: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_FINISH && push && push_item.last) ||
		        (state_q == ST_IDLE && !head.cmd.is_frame))
		else $error("queue popped outside load or frame end");

	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hits_q) <= MAX_OUT)
		else $error("hit count beyond limit");

endmodule

### hw/rtl/can_frame_rule_matcher_unit.sv
// ----------------------------------------------------------------------------
// can_frame_rule_matcher_unit
// CAN id/mask filter with payload pattern search over a table of rules.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): func 0 loads one rule slot and
//   gives no result; func 1 checks a frame against every valid rule.
//   rsp channel (rsp_valid/rsp_stall/rsp): one result per hit in ascending
//   rule order with a running hit_count, last set on the final one; a frame
//   with no hit gives a single result with hit 0 and last 1.
//   Items go through a two-entry queue into the engine; req_stall rises only
//   when that queue is full.
//   Sequence: a load is written to the table as it leaves the queue. A
//   frame goes through a start step, a walk over the table rule by rule
//   and a finish step that posts the final result. The first result is
//   registered on the second hit, or at the end of the walk with at most
//   one hit.
//   A stalled receiver holds the output register; the engine keeps walking
//   until a second hit needs the register, then waits.
//   Reset clears the queue and output and loads slot 0 with the error-frame
//   rule and slot 1 with the 0x7df rule, all others invalid.
// ----------------------------------------------------------------------------
module can_frame_rule_matcher_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  cfrm_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cfrm_pkg::rsp_item_t rsp
);
	import cfrm_pkg::*;

	q_head_t head;
	logic    pop;

	// accept and queue
	cfrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	// rule table walk and results
	cfrm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### tb/sv/tb_can_frame_rule_matcher_unit.sv
// ----------------------------------------------------------------------------
// tb_can_frame_rule_matcher_unit
// Self-checking bench for the CAN frame rule matcher. Rule loads and frames
// are driven over the request channel. A scoreboard keeps its own copy of the
// rule table and predicts the hit list of each frame. Every result is checked
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_can_frame_rule_matcher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cfrm_pkg::*;

	localparam int RANDOM_ITEMS  = 450;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 2 * NUM_RULES + 8;

	// rule table mirror and ordered store of expected hit results
	class hit_scoreboard;
		logic [31:0] id_tab[NUM_RULES];
		logic [31:0] mask_tab[NUM_RULES];
		logic [63:0] pat_tab[NUM_RULES];
		int unsigned plen_tab[NUM_RULES];
		bit          on_tab[NUM_RULES];
		rsp_item_t   expected_hits_q[$];
		int unsigned errors, frames, loads, hit_results, miss_results, max_hits;

		function new();
			foreach (id_tab[i]) begin
				id_tab[i]   = '0;
				mask_tab[i] = '0;
				pat_tab[i]  = '0;
				plen_tab[i] = 0;
				on_tab[i]   = 1'b0;
			end
			id_tab[0]   = ERR_RULE_ID;
			mask_tab[0] = ERR_RULE_ID;
			on_tab[0]   = 1'b1;
			id_tab[1]   = OBD_RULE_ID;
			mask_tab[1] = SFF_RULE_MASK;
			on_tab[1]   = 1'b1;
		endfunction

		function int unsigned sat_len(logic [3:0] l);
			return (32'(l) > MAX_DATA_BYTES) ? MAX_DATA_BYTES : 32'(l);
		endfunction

		// zero id with zero mask passes everything, zero mask alone means full 29 bits
		function bit id_passes(logic [31:0] fid, logic [31:0] rid, logic [31:0] rmask);
			logic [31:0] m;
			if (rid == '0 && rmask == '0)
				return 1'b1;
			m = (rmask != '0) ? rmask : ID_FULL_MASK;
			return (fid & m) == (rid & m);
		endfunction

		// pattern search at every byte offset inside the frame payload
		function bit pattern_in(logic [63:0] payload, int unsigned flen,
				logic [63:0] pat, int unsigned plen);
			bit same;
			if (plen == 0)
				return 1'b1;
			for (int unsigned off = 0; off + plen <= flen; off++) begin
				same = 1'b1;
				for (int unsigned k = 0; k < plen; k++)
					if (payload[8*(off+k) +: 8] != pat[8*k +: 8])
						same = 1'b0;
				if (same)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// accepted request item: update the table or queue the frame's hits
		function void note_item(req_item_t it);
			rsp_item_t r;
			int unsigned hits, flen;
			int unsigned s;
			if (it.func == FUNC_LOAD) begin
				loads++;
				s = 32'(it.index);
				if (s < NUM_RULES) begin
					on_tab[s]   = it.rule_valid;
					id_tab[s]   = it.rule_valid ? it.can_id : '0;
					mask_tab[s] = it.rule_valid ? it.mask : '0;
					pat_tab[s]  = it.rule_valid ? it.data : '0;
					plen_tab[s] = it.rule_valid ? sat_len(it.length) : 0;
				end
				return;
			end
			frames++;
			hits = 0;
			flen = sat_len(it.length);
			for (int unsigned i = 0; i < NUM_RULES && hits < MAX_OUT; i++) begin
				if (on_tab[i] && id_passes(it.can_id, id_tab[i], mask_tab[i]) &&
						pattern_in(it.data, flen, pat_tab[i], plen_tab[i])) begin
					hits++;
					r.rule_index = 4'(i);
					r.hit        = 1'b1;
					r.hit_count  = 5'(hits);
					r.last       = 1'b0;
					expected_hits_q.push_back(r);
				end
			end
			if (hits == 0) begin
				r = '0;
				r.last = 1'b1;
				expected_hits_q.push_back(r);
			end else begin
				expected_hits_q[$].last = 1'b1;
			end
			if (hits > max_hits)
				max_hits = hits;
		endfunction

		// accepted result item against the oldest expectation
		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (expected_hits_q.size() == 0) begin
				errors++;
				$error("result with nothing expected: %p", got);
				return;
			end
			want = expected_hits_q.pop_front();
			if (got.hit)
				hit_results++;
			else
				miss_results++;
			if (got.rule_index != want.rule_index) begin
				errors++;
				$error("rule_index: expected %0d, got %0d", want.rule_index, got.rule_index);
			end
			if (got.hit != want.hit) begin
				errors++;
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
			end
			if (got.hit_count != want.hit_count) begin
				errors++;
				$error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
			end
			if (got.last != want.last) begin
				errors++;
				$error("last: expected %0d, got %0d", want.last, got.last);
			end
		endfunction

		function int pending();
			return expected_hits_q.size();
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	bit            no_gaps = 1'b0;
	int unsigned   quiet_cycles = 0;
	hit_scoreboard sb = new();

	can_frame_rule_matcher_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// accepted items on both channels
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_item(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// receiver backpressure
	always @(posedge clk) begin
		rsp_stall <= !no_gaps && ($urandom_range(99) < 12);
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", sb.pending());
			$display("can_frame_rule_matcher_unit regression: fail");
			$finish;
		end
	end

	// one item over the request channel, with random gaps ahead of it
	task automatic send_item(input req_item_t it);
		while (!no_gaps && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// hold the sender until every expected result has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic req_item_t random_item();
		req_item_t it;
		it.func       = 1'($urandom_range(1));
		it.index      = 4'($urandom_range(15));
		it.can_id     = $urandom;
		it.mask       = $urandom;
		it.data       = {$urandom, $urandom};
		it.length     = 4'($urandom_range(15));
		it.rule_valid = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic send_load(input logic [3:0] idx, input logic [31:0] id,
			input logic [31:0] msk, input logic [63:0] pat, input logic [3:0] len,
			input logic on);
		req_item_t it;
		it            = random_item();
		it.func       = FUNC_LOAD;
		it.index      = idx;
		it.can_id     = id;
		it.mask       = msk;
		it.data       = pat;
		it.length     = len;
		it.rule_valid = on;
		send_item(it);
	endtask

	task automatic send_frame(input logic [31:0] id, input logic [63:0] payload,
			input logic [3:0] len);
		req_item_t it;
		it        = random_item();
		it.func   = FUNC_CHECK;
		it.can_id = id;
		it.data   = payload;
		it.length = len;
		send_item(it);
	endtask

	// random rule: a mix of match-all, standard id, full mask and odd masks
	task automatic send_random_load();
		req_item_t it;
		it            = random_item();
		it.func       = FUNC_LOAD;
		it.rule_valid = ($urandom_range(6) != 0);
		case ($urandom_range(4))
			0: begin
				it.can_id = '0;
				it.mask   = '0;
			end
			1: begin
				it.can_id = $urandom_range(11'h7FF);
				it.mask   = SFF_RULE_MASK;
			end
			2: it.mask = ID_FULL_MASK;
			3: it.mask = '0;
			default: it.mask = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
		endcase
		it.length = ($urandom_range(7) != 0) ? 4'($urandom_range(3))
		                                      : 4'($urandom_range(15));
		send_item(it);
	endtask

	// frame aimed at a live rule most of the time, pattern planted in the payload
	task automatic send_random_frame();
		req_item_t   it;
		int          slot, start;
		int unsigned plen, flen, off, k;
		logic [31:0] m;
		it      = random_item();
		it.func = FUNC_CHECK;
		if ($urandom_range(3) != 0) begin
			slot  = -1;
			start = $urandom_range(NUM_RULES - 1);
			for (k = 0; k < NUM_RULES; k++)
				if (slot < 0 && sb.on_tab[(start + k) % NUM_RULES])
					slot = (start + k) % NUM_RULES;
			if (slot >= 0) begin
				m = (sb.mask_tab[slot] != '0) ? sb.mask_tab[slot] : ID_FULL_MASK;
				if (sb.id_tab[slot] == '0 && sb.mask_tab[slot] == '0)
					m = '0;
				it.can_id = (sb.id_tab[slot] & m) | (it.can_id & ~m);
				plen      = sb.plen_tab[slot];
				it.length = 4'($urandom_range(15, plen));
				flen      = sb.sat_len(it.length);
				if (plen > 0 && $urandom_range(4) != 0) begin
					off = $urandom_range(flen - plen);
					for (k = 0; k < plen; k++)
						it.data[8*(off+k) +: 8] = sb.pat_tab[slot][8*k +: 8];
				end
			end
		end
		send_item(it);
	endtask

	// stimulus and end of run
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rules, no-hit, flag bits above the 29-bit id
		send_frame(32'h0000_0000, 64'h0, 4'd0);
		send_frame(OBD_RULE_ID, 64'h0123_4567_89AB_CDEF, 4'd8);
		send_frame(ERR_RULE_ID, 64'h0, 4'd3);
		send_frame(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		send_frame(32'h2000_07DF, 64'h0, 4'd1);
		// match-all rule
		send_load(4'd2, 32'h0, 32'h0, 64'hDEAD_BEEF_0000_0000, 4'd0, 1'b1);
		send_frame(32'h1234_5678, 64'h5555_AAAA_5555_AAAA, 4'd4);
		// zero mask stands for the full 29-bit id, pattern at an offset
		send_load(4'd3, 32'h0000_0123, 32'h0, 64'h0000_0000_0000_AABB, 4'd2, 1'b1);
		send_frame(32'hE000_0123, 64'h00AA_BB00_0000_0000, 4'd8);
		// pattern sits past the frame length, then pattern longer than frame
		send_frame(32'h0000_0123, 64'h00AA_BB00_0000_0000, 4'd6);
		send_frame(32'h0000_0123, 64'h0000_0000_0000_AABB, 4'd1);
		// pattern and frame lengths above eight saturate
		send_load(4'd4, 32'h0000_0055, 32'h0000_00FF, 64'h0102_0304_0506_0708, 4'd12,
			1'b1);
		send_frame(32'h0000_0155, 64'h0102_0304_0506_0708, 4'd12);
		// clearing a slot wipes the whole rule
		send_load(4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
			1'b0);
		send_frame(32'h0000_0000, 64'h0, 4'd0);
		send_load(4'd15, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
			1'b1);
		send_frame(32'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_load(4'd15, 32'h0, 32'h0, 64'h0, 4'd0, 1'b0);
		send_load(4'd0, 32'h0, 32'h0, 64'h0, 4'd0, 1'b0);
		send_frame(ERR_RULE_ID, 64'h0, 4'd0);
		drain();

		// random traffic with a quiet window and a full-table burst
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = (n >= 100 && n < 180);
			if (n == 225)
				drain();
			if (n == 300) begin
				for (int s = 0; s < NUM_RULES; s++)
					send_load(4'(s), 32'h0, 32'h0, {$urandom, $urandom}, 4'd0, 1'b1);
				send_frame($urandom, {$urandom, $urandom}, 4'($urandom_range(15)));
			end
			if ($urandom_range(9) < 3)
				send_random_load();
			else
				send_random_frame();
		end
		no_gaps = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.errors++;
			$error("%0d expected results never arrived", sb.pending());
		end
		$display("covered %0d rule loads and %0d frames, up to %0d hits on one frame",
			sb.loads, sb.frames, sb.max_hits);
		$display("checked %0d hit results and %0d no-hit results, %0d mismatches",
			sb.hit_results, sb.miss_results, sb.errors);
		if (sb.errors == 0)
			$display("can_frame_rule_matcher_unit regression: pass");
		else
			$display("can_frame_rule_matcher_unit regression: fail");
		$finish;
	end

endmodule
